// ===== hdl/lpfd_pkg.sv =====
// shared types and constants of the length-prefixed frame deframer
package lpfd_pkg;

	localparam int unsigned HDR_IDX_W   = 5;
	localparam int unsigned WORD_W      = 32;
	localparam int unsigned LEFT_W      = 23;
	localparam int unsigned KIND_W      = 2;

	localparam logic [HDR_IDX_W-1:0] HDR_MAGIC_END = 5'd3;
	localparam logic [HDR_IDX_W-1:0] HDR_TYPE_END  = 5'd7;
	localparam logic [HDR_IDX_W-1:0] HDR_LEN_START = 5'd28;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST      = 5'd31;

	localparam logic [WORD_W-1:0] MAGIC_RESET       = 32'h33CC_CC33;
	localparam logic [LEFT_W-1:0] MAX_PAYLOAD_RESET = 23'd4194304;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_HALT    = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MAGIC = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] result_kind;
		logic [WORD_W-1:0] frame_kind;
		logic [WORD_W-1:0] frame_bytes;
		logic [7:0]        payload_byte;
		logic              last_of_frame;
	} lpfd_result_t;

	typedef struct packed {
		logic halted;
		logic in_payload;
	} lpfd_status_t;

endpackage

// ===== hdl/lpfd_if.sv =====
// channel interfaces: incoming byte stream and outgoing results
interface lpfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

interface lpfd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [31:0] frame_kind;
	logic [31:0] frame_bytes;
	logic [7:0]  payload_byte;
	logic        last_of_frame;

	modport source (output valid, output result_kind, output frame_kind, output frame_bytes,
		output payload_byte, output last_of_frame, input ready);
	modport sink (input valid, input result_kind, input frame_kind, input frame_bytes,
		input payload_byte, input last_of_frame, output ready);
endinterface

// ===== hdl/lpfd_parse.sv =====
// header parser and payload counter, one byte per step
module lpfd_parse
	import lpfd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        byte_in,
	input  logic [WORD_W-1:0] frame_magic,
	input  logic [LEFT_W-1:0] max_payload,
	output logic              res_valid,
	output lpfd_result_t      res,
	output lpfd_status_t      status
);

	logic [HDR_IDX_W-1:0] header_index_q;
	logic [WORD_W-1:0]    magic_word_q;
	logic [WORD_W-1:0]    type_word_q;
	logic [WORD_W-1:0]    length_word_q;
	logic [LEFT_W-1:0]    payload_left_q;
	logic                 in_payload_q;
	logic                 halted_q;

	logic [WORD_W-1:0] length_next;
	logic              hdr_done;
	logic              hdr_bad;

	assign length_next = {byte_in, length_word_q[WORD_W-1:8]};
	assign hdr_done    = !halted_q && !in_payload_q && (header_index_q == HDR_LAST);
	assign hdr_bad     = (magic_word_q != frame_magic)
		|| (length_next > {{(WORD_W-LEFT_W){1'b0}}, max_payload});

	always_comb begin
		res_valid         = 1'b0;
		res.result_kind   = KIND_PAYLOAD;
		res.frame_kind    = type_word_q;
		res.frame_bytes   = length_word_q;
		res.payload_byte  = 8'd0;
		res.last_of_frame = 1'b0;
		if (step && !halted_q) begin
			if (in_payload_q) begin
				res_valid         = 1'b1;
				res.payload_byte  = byte_in;
				res.last_of_frame = (payload_left_q <= LEFT_W'(1));
			end else if (hdr_done) begin
				res.frame_bytes = length_next;
				if (hdr_bad) begin
					res_valid       = 1'b1;
					res.result_kind = KIND_HALT;
				end else if (length_next == '0) begin
					res_valid         = 1'b1;
					res.result_kind   = KIND_EMPTY;
					res.last_of_frame = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_index_q <= '0;
			magic_word_q   <= '0;
			type_word_q    <= '0;
			length_word_q  <= '0;
			payload_left_q <= '0;
			in_payload_q   <= 1'b0;
			halted_q       <= 1'b0;
		end else if (step && !halted_q) begin
			if (in_payload_q) begin
				if (payload_left_q <= LEFT_W'(1)) begin
					payload_left_q <= '0;
					in_payload_q   <= 1'b0;
				end else begin
					payload_left_q <= payload_left_q - LEFT_W'(1);
				end
			end else begin
				header_index_q <= header_index_q + HDR_IDX_W'(1);
				if (header_index_q <= HDR_MAGIC_END)
					magic_word_q <= {byte_in, magic_word_q[WORD_W-1:8]};
				else if (header_index_q <= HDR_TYPE_END)
					type_word_q <= {byte_in, type_word_q[WORD_W-1:8]};
				else if (header_index_q >= HDR_LEN_START)
					length_word_q <= length_next;
				if (hdr_done) begin
					if (hdr_bad) begin
						halted_q <= 1'b1;
					end else if (length_next != '0) begin
						payload_left_q <= length_next[LEFT_W-1:0];
						in_payload_q   <= 1'b1;
					end
				end
			end
		end
	end

	assign status.halted     = halted_q;
	assign status.in_payload = in_payload_q;

endmodule

// ===== hdl/lpfd_out_buf.sv =====
// two-entry result buffer: output register plus skid entry
module lpfd_out_buf
	import lpfd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  lpfd_result_t  push_data,
	output logic          full,
	lpfd_result_if.source out_ch
);

	logic         main_valid_q;
	logic         skid_valid_q;
	lpfd_result_t main_q;
	lpfd_result_t skid_q;
	logic         main_free;

	assign main_free = !main_valid_q || out_ch.ready;
	assign full      = skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (main_free) begin
			main_valid_q <= skid_valid_q || push;
			skid_valid_q <= skid_valid_q && push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (main_free) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

	assign out_ch.valid         = main_valid_q;
	assign out_ch.result_kind   = main_q.result_kind;
	assign out_ch.frame_kind    = main_q.frame_kind;
	assign out_ch.frame_bytes   = main_q.frame_bytes;
	assign out_ch.payload_byte  = main_q.payload_byte;
	assign out_ch.last_of_frame = main_q.last_of_frame;

endmodule

// ===== hdl/length_prefixed_frame_deframer.sv =====
// top level of the length-prefixed frame deframer
//
// usage:
//   in_ch carries the frame stream, one byte per item. every frame is a
//   32-byte header (little-endian magic at byte 0, type at byte 4, payload
//   length at byte 28) followed by the payload bytes.
//   out_ch gives one item per payload byte (type and length attached, last
//   byte flagged), one item for a valid empty frame, or one halt item for a
//   bad magic or a length above max_payload. header bytes but the last give no item.
//   cfg_we/cfg_index/cfg_data write frame_magic (index 0) and max_payload
//   (index 1); write them only while the block is idle.
// throughput: one byte per cycle while the skid entry is free, set by the
//   combinational parser between the input register and the result buffer.
// path: input register, parser, then the result buffer's output register.
// reset: arst_n clears the parser (expecting a header, not halted), empties
//   the buffers and restores the register defaults.
// stall: the two-entry result buffer absorbs one extra item; in_ch.ready
//   drops only once the skid entry fills. after a halt every byte is
//   accepted and dropped until reset.
module length_prefixed_frame_deframer
	import lpfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	lpfd_byte_if.sink            in_ch,
	lpfd_result_if.source        out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	// configuration registers
	logic [WORD_W-1:0] frame_magic_q;
	logic [LEFT_W-1:0] max_payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_magic_q <= MAGIC_RESET;
			max_payload_q <= MAX_PAYLOAD_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_MAGIC: frame_magic_q <= cfg_data;
				CFG_MAX_PAYLOAD: max_payload_q <= cfg_data[LEFT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register stage
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         buf_full;
	logic         advance;
	logic         step;
	logic         res_valid;
	lpfd_result_t res;
	lpfd_status_t status;

	// the stage moves on whenever the skid entry is free, so ready never
	// depends on out_ch.ready through logic
	assign advance     = !buf_full;
	assign step        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			byte_s1 <= in_ch.stream_byte;
	end

	// header parse, checks and payload counting
	lpfd_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.byte_in     (byte_s1),
		.frame_magic (frame_magic_q),
		.max_payload (max_payload_q),
		.res_valid   (res_valid),
		.res         (res),
		.status      (status)
	);

	// result register and skid entry
	lpfd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.full      (buf_full),
		.out_ch    (out_ch)
	);

	// once halted, the parser stays halted until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |=> status.halted)
		else $error("halt flag cleared without reset");

	// a halted parser never sits in a payload
	a_halt_no_payload: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |-> !status.in_payload)
		else $error("payload state while halted");

	// the skid entry only fills behind a held output register
	a_skid_behind_main: assert property (@(posedge clk) disable iff (!arst_n)
		buf_full |-> out_ch.valid)
		else $error("skid entry valid with empty output register");

	// no result is produced after the parser has halted
	a_quiet_after_halt: assert property (@(posedge clk) disable iff (!arst_n)
		status.halted |-> !res_valid)
		else $error("result produced while halted");

endmodule

// ===== test/lpfd_checker.sv =====
`timescale 1ns / 100ps
// checker for the frame deframer: tracks both channels and the register port, predicts every item
module lpfd_checker
	import lpfd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	lpfd_byte_if                 in_ch,
	lpfd_result_if               out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	output int                   errors,
	output int                   pending
);

	logic [WORD_W-1:0]    magic_reg;
	logic [LEFT_W-1:0]    max_reg;
	logic [HDR_IDX_W-1:0] hdr_pos;
	logic [WORD_W-1:0]    magic_acc;
	logic [WORD_W-1:0]    type_acc;
	logic [WORD_W-1:0]    len_acc;
	logic [LEFT_W-1:0]    bytes_due;
	logic                 in_body;
	logic                 stopped;
	lpfd_result_t         due_q[$];

	function automatic lpfd_result_t make_result(input logic [KIND_W-1:0] k,
		input logic [7:0] b, input logic last);
		lpfd_result_t r;
		r.result_kind   = k;
		r.frame_kind    = type_acc;
		r.frame_bytes   = len_acc;
		r.payload_byte  = b;
		r.last_of_frame = last;
		return r;
	endfunction

	// one stream byte through the parser, queueing the item it causes
	task automatic deframe_byte(input logic [7:0] b);
		logic [HDR_IDX_W-1:0] pos;
		if (stopped)
			return;
		if (in_body) begin
			due_q.push_back(make_result(KIND_PAYLOAD, b, bytes_due <= 1));
			if (bytes_due > 0)
				bytes_due = bytes_due - 1'b1;
			if (bytes_due == 0)
				in_body = 1'b0;
			return;
		end
		pos = hdr_pos;
		if (pos <= HDR_MAGIC_END)
			magic_acc = {b, magic_acc[WORD_W-1:8]};
		else if (pos <= HDR_TYPE_END)
			type_acc = {b, type_acc[WORD_W-1:8]};
		else if (pos >= HDR_LEN_START)
			len_acc = {b, len_acc[WORD_W-1:8]};
		hdr_pos = hdr_pos + 1'b1;
		if (pos != HDR_LAST)
			return;
		if (magic_acc != magic_reg || len_acc > {{(WORD_W-LEFT_W){1'b0}}, max_reg}) begin
			stopped = 1'b1;
			due_q.push_back(make_result(KIND_HALT, 8'h00, 1'b0));
		end else if (len_acc == 0) begin
			due_q.push_back(make_result(KIND_EMPTY, 8'h00, 1'b1));
		end else begin
			bytes_due = len_acc[LEFT_W-1:0];
			in_body   = 1'b1;
		end
	endtask

	task automatic flag_field(input string field, input logic [WORD_W-1:0] want,
		input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", field, want, got);
			errors++;
		end
	endtask

	task automatic compare_result();
		lpfd_result_t want;
		if (due_q.size() == 0) begin
			$error("unexpected item: result_kind %0d payload_byte %h",
				out_ch.result_kind, out_ch.payload_byte);
			errors++;
			return;
		end
		want = due_q.pop_front();
		flag_field("result_kind", want.result_kind, out_ch.result_kind);
		flag_field("frame_kind", want.frame_kind, out_ch.frame_kind);
		flag_field("frame_bytes", want.frame_bytes, out_ch.frame_bytes);
		flag_field("payload_byte", want.payload_byte, out_ch.payload_byte);
		flag_field("last_of_frame", want.last_of_frame, out_ch.last_of_frame);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_reg = MAGIC_RESET;
			max_reg   = MAX_PAYLOAD_RESET;
			hdr_pos   = '0;
			magic_acc = '0;
			type_acc  = '0;
			len_acc   = '0;
			bytes_due = '0;
			in_body   = 1'b0;
			stopped   = 1'b0;
			errors    = 0;
			due_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_MAGIC)
					magic_reg = cfg_data;
				else if (cfg_index == CFG_MAX_PAYLOAD)
					max_reg = cfg_data[LEFT_W-1:0];
			end
			if (out_ch.valid && out_ch.ready)
				compare_result();
			if (in_ch.valid && in_ch.ready)
				deframe_byte(in_ch.stream_byte);
			pending <= due_q.size();
		end
	end

endmodule

// ===== test/length_prefixed_frame_deframer_tb.sv =====
`timescale 1ns / 100ps
// top of the frame deframer testbench: clock, reset, byte stream, register writes and verdict
module length_prefixed_frame_deframer_tb;
	import lpfd_pkg::*;

	// bytes sent in the random part
	localparam int unsigned RANDOM_BYTES = 640;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;
	int                   fail_count;
	int                   pending_results;

	// sender bookkeeping
	int                   burst_left;
	int unsigned          bytes_sent;
	// register values as last written, used to build legal frames and the bad header
	logic [WORD_W-1:0]    cur_magic;
	logic [LEFT_W-1:0]    cur_max;

	lpfd_byte_if   in_ch();
	lpfd_result_if out_ch();

	length_prefixed_frame_deframer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lpfd_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (fail_count),
		.pending   (pending_results)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the handshake hangs
	initial begin
		#5ms;
		$display("length_prefixed_frame_deframer test failed");
		$finish;
	end

	// result side: hold off at the start, then a mix of open stretches,
	// random stalls, short holds and the odd long hold
	initial begin : receiver
		int span;
		int mode;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		// first item shows up while the sender keeps pushing payload: keep ready
		// low long enough for the result buffer to fill and in_ch.ready to drop
		while (!out_ch.valid)
			@(posedge clk);
		repeat (100) @(posedge clk);
		forever begin
			span = $urandom_range(1, 40);
			mode = $urandom_range(0, 29);
			if (mode < 12) begin
				out_ch.ready <= 1'b1;
				repeat (span) @(posedge clk);
			end else if (mode < 22) begin
				repeat (span) begin
					out_ch.ready <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
			end else if (mode < 29) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end else begin
				// long hold, the sender runs into backpressure again
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(60, 150)) @(posedge clk);
			end
		end
	end

	// one item on the byte channel; bursts of random length with gaps between
	task automatic push_byte(input logic [7:0] b);
		if (burst_left == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 20);
		end
		burst_left--;
		in_ch.valid       <= 1'b1;
		in_ch.stream_byte <= b;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// stop sending, let every expected item drain, then give the pipeline
	// time to run idle, since header bytes leave nothing to wait on
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_FRAME_MAGIC)
			cur_magic = val;
		else
			cur_max = val[LEFT_W-1:0];
	endtask

	// header byte k: little-endian magic, type and length, filler elsewhere
	function automatic logic [7:0] header_byte(input int k, input logic [WORD_W-1:0] magic,
		input logic [WORD_W-1:0] ftype, input logic [WORD_W-1:0] len);
		if (k < 4)
			return magic[8*k +: 8];
		if (k < 8)
			return ftype[8*(k-4) +: 8];
		if (k >= 28)
			return len[8*(k-28) +: 8];
		return 8'($urandom);
	endfunction

	task automatic send_header(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] ftype,
		input logic [WORD_W-1:0] len, input int first, input int count);
		for (int k = first; k < first + count; k++)
			push_byte(header_byte(k, magic, ftype, len));
	endtask

	task automatic send_payload(input int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			push_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input logic [WORD_W-1:0] magic, input logic [WORD_W-1:0] ftype,
		input int unsigned len);
		send_header(magic, ftype, len, 0, 32);
		send_payload(len);
	endtask

	function automatic logic [WORD_W-1:0] pick_type();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// legal length under the current limit: mostly short, now and then longer
	function automatic int unsigned pick_length();
		int unsigned cap;
		cap = ($urandom_range(0, 9) == 0) ? 300 : 48;
		if (cur_max < cap)
			cap = cur_max;
		if ($urandom_range(0, 5) == 0)
			return 0;
		return $urandom_range(0, cap);
	endfunction

	initial begin : stimulus
		int unsigned       mark;
		int                flaw;
		logic [WORD_W-1:0] bad_magic;
		logic [WORD_W-1:0] bad_len;

		arst_n            <= 1'b0;
		in_ch.valid       <= 1'b0;
		in_ch.stream_byte <= 8'h00;
		cfg_we            <= 1'b0;
		cfg_index         <= CFG_FRAME_MAGIC;
		cfg_data          <= '0;
		burst_left = 0;
		bytes_sent = 0;
		cur_magic  = MAGIC_RESET;
		cur_max    = MAX_PAYLOAD_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// defaults after reset; the long payload runs into the opening hold
		send_frame(MAGIC_RESET, 32'hFFFF_FFFF, 40);
		// valid empty frame
		send_frame(MAGIC_RESET, 32'h0000_0000, 0);
		// single payload byte, first byte is also the last
		send_frame(MAGIC_RESET, 32'h8000_0001, 1);

		// all-zero magic; limit written with every bit set, upper bits fall away
		settle();
		write_reg(CFG_FRAME_MAGIC, 32'h0000_0000);
		write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
		send_frame(32'h0000_0000, $urandom, 3);

		// magic changed halfway through a header: the check at the last
		// header byte must use the new value
		send_header(32'hFFFF_FFFF, 32'h1234_5678, 2, 0, 16);
		settle();
		write_reg(CFG_FRAME_MAGIC, 32'hFFFF_FFFF);
		send_header(32'hFFFF_FFFF, 32'h1234_5678, 2, 16, 16);
		send_payload(2);

		// zero limit still lets an empty frame through
		settle();
		write_reg(CFG_MAX_PAYLOAD, 32'h0000_0000);
		send_frame(32'hFFFF_FFFF, 32'h0000_0000, 0);

		// limit of 32 with junk in the upper bits; length right at the limit
		settle();
		write_reg(CFG_MAX_PAYLOAD, 32'hFF80_0020);
		send_frame(32'hFFFF_FFFF, $urandom, 32);

		// --- random part: phases of a few legal frames under a fresh setting ---
		mark = bytes_sent;
		while (bytes_sent - mark < RANDOM_BYTES) begin
			settle();
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(CFG_FRAME_MAGIC, 32'h0000_0000);
					1: write_reg(CFG_FRAME_MAGIC, 32'hFFFF_FFFF);
					2: write_reg(CFG_FRAME_MAGIC, MAGIC_RESET);
					default: write_reg(CFG_FRAME_MAGIC, $urandom);
				endcase
			end
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 5))
					0: write_reg(CFG_MAX_PAYLOAD, 32'h0000_0000);
					1: write_reg(CFG_MAX_PAYLOAD, 32'hFFFF_FFFF);
					2: write_reg(CFG_MAX_PAYLOAD, 32'(MAX_PAYLOAD_RESET));
					3: write_reg(CFG_MAX_PAYLOAD, $urandom_range(1, 64));
					default: write_reg(CFG_MAX_PAYLOAD,
						($urandom & 32'hFF80_0000) | $urandom_range(1, 300));
				endcase
			end
			repeat ($urandom_range(2, 6))
				send_frame(cur_magic, pick_type(), pick_length());
		end

		// --- closing: one broken header halts the block for good ---
		flaw      = $urandom_range(0, 2);
		bad_magic = cur_magic;
		bad_len   = pick_length();
		// flaw 0: wrong magic, 1: length over the limit, 2: both
		if (flaw != 1)
			bad_magic = cur_magic ^ (32'h1 << $urandom_range(0, 31));
		if (flaw != 0)
			bad_len = ($urandom_range(0, 1) == 0) ? 32'(cur_max) + 32'd1
				: ($urandom | 32'h0080_0000);
		send_header(bad_magic, $urandom, bad_len, 0, 32);
		// swallowed without any item
		send_payload(24);

		settle();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("length_prefixed_frame_deframer test passed");
		else
			$display("length_prefixed_frame_deframer test failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/lpfd_pkg.sv
hdl/lpfd_if.sv
hdl/lpfd_parse.sv
hdl/lpfd_out_buf.sv
hdl/length_prefixed_frame_deframer.sv
test/lpfd_checker.sv
test/length_prefixed_frame_deframer_tb.sv
